// ===== hdl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg: shared types and codes for the positional array list
// Request and response beat layouts, operation codes, status codes and the
// shift command that the top level hands to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  // Fixed field widths of the request and response beats
  localparam int unsigned OpW   = 2;
  localparam int unsigned PosW  = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned StW   = 2;
  localparam int unsigned CntW  = 5;

  // Operation codes; OP_NOP leaves the list untouched and answers ok
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } pal_op_e;

  // Status codes carried by every response
  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pal_status_e;

  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } pal_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [StW-1:0]          status;
    logic [CntW-1:0]         count;
  } pal_rsp_t;

  // Command broadcast to the cell row for one accepted beat
  typedef struct packed {
    logic ins;
    logic del;
  } pal_shift_t;

endpackage

`default_nettype wire

// ===== hdl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell: one storage slot of the list
// Holds a single entry. On insert it takes its lower neighbor (or the new
// value at the addressed slot); on delete it takes its upper neighbor.
// Drives its entry onto the read bus when its slot is addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CmpW = 5
) (
  input  wire logic                              clk_i,
  input  wire pal_pkg::pal_shift_t               shift_i,
  input  wire logic [CmpW-1:0]                   pos_i,
  input  wire logic signed [pal_pkg::DataW-1:0]  value_i,
  input  wire logic signed [pal_pkg::DataW-1:0]  lower_i,
  input  wire logic signed [pal_pkg::DataW-1:0]  upper_i,
  output logic signed [pal_pkg::DataW-1:0]       entry_o,
  output logic signed [pal_pkg::DataW-1:0]       sel_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(Idx);

  logic signed [pal_pkg::DataW-1:0] entry_q, entry_d;
  logic                             hit, above;

  assign hit   = (pos_i == MyIdx);
  assign above = (MyIdx > pos_i);

  // Pick the next content of this slot
  always_comb begin
    entry_d = entry_q;
    if (shift_i.ins) begin
      if (hit) begin
        entry_d = value_i;
      end else if (above) begin
        entry_d = lower_i;
      end
    end else if (shift_i.del) begin
      if (hit || above) begin
        entry_d = upper_i;
      end
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign sel_o   = hit ? entry_q : '0;

endmodule

`default_nettype wire

// ===== hdl/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list: bounded ordered list with insert/delete at position
// A row of DEPTH cells, each holding one entry, shifts as a whole to open
// or close a gap at the addressed position.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats arrive on in_valid_i / in_req_i; the block holds off with
//   in_stall_o. Each beat gives one response beat on out_valid_o / out_rsp_o,
//   taken when out_stall_i is low.
//   The response is registered at the edge that takes the request. One
//   request per cycle is sustained unless out_stall_i holds a response;
//   all cells shift in the same edge, so the count register is the only loop.
//   While a response waits under out_stall_i, in_stall_o is high and no new
//   request is taken; the waiting response holds steady.
//   Reset clears the count and the response valid; entry contents are left
//   as they are and are never read before being written.
//   Status: ok, full (insert into full list), empty (delete/read on empty
//   list), range (position past the end). Data is zero for insert and on
//   every error. Count reports the entries held after the operation.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pal_pkg::pal_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pal_pkg::pal_rsp_t      out_rsp_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CW > pal_pkg::PosW) ? CW : pal_pkg::PosW;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  pal_pkg::pal_rsp_t     rsp_q, rsp_d;
  logic                  accept;
  logic [CmpW-1:0]       pos_ext, cnt_ext;
  pal_pkg::pal_op_e      op;
  pal_pkg::pal_status_e  status;
  pal_pkg::pal_shift_t   shift;
  logic signed [pal_pkg::DataW-1:0] rd_data;

  logic signed [pal_pkg::DataW-1:0] entry [DEPTH];
  logic signed [pal_pkg::DataW-1:0] sel   [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign op      = pal_pkg::pal_op_e'(in_req_i.opcode);
  assign pos_ext = CmpW'(in_req_i.position);
  assign cnt_ext = CmpW'(count_q);

  // Decide status and the shift command for this beat
  always_comb begin
    status    = pal_pkg::ST_OK;
    shift.ins = 1'b0;
    shift.del = 1'b0;
    unique case (op)
      pal_pkg::OP_INSERT: begin
        if (count_q == Full) begin
          status = pal_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = pal_pkg::ST_RANGE;
        end else begin
          shift.ins = accept;
        end
      end
      pal_pkg::OP_DELETE, pal_pkg::OP_READ: begin
        if (count_q == '0) begin
          status = pal_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = pal_pkg::ST_RANGE;
        end else begin
          shift.del = accept && (op == pal_pkg::OP_DELETE);
        end
      end
      default: begin
        status = pal_pkg::ST_OK;
      end
    endcase
  end

  // Cell row: each slot talks to its two neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [pal_pkg::DataW-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = entry[g];
    end else begin : g_mid
      assign lower = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = entry[g];
    end else begin : g_inner
      assign upper = entry[g+1];
    end
    pal_cell #(
      .Idx  (g),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .pos_i   (pos_ext),
      .value_i (in_req_i.value),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[g]),
      .sel_o   (sel[g])
    );
  end

  // Gather the addressed entry from the read bus
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | sel[i];
    end
  end

  // Advance the count and build the response beat
  always_comb begin
    count_d = count_q;
    if (shift.ins) begin
      count_d = count_q + CW'(1);
    end else if (shift.del) begin
      count_d = count_q - CW'(1);
    end
    rsp_d.status = status;
    rsp_d.count  = pal_pkg::CntW'(count_d);
    if ((status == pal_pkg::ST_OK) &&
        ((op == pal_pkg::OP_DELETE) || (op == pal_pkg::OP_READ))) begin
      rsp_d.data = rd_data;
    end else begin
      rsp_d.data = '0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Response payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the positional array list
// Drives request beats through a valid/stall sender with random gaps. Each
// accepted beat runs through a behavioral copy of the list, and that copy
// yields the expected response. A checker compares every response beat,
// field by field, against the oldest expected response. Directed cases cover
// the empty, full and out-of-range paths. Random traffic follows the list's
// count so that most requests land on valid positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LIST_DEPTH = 16;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  pal_pkg::pal_req_t in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pal_pkg::pal_rsp_t out_rsp_o;

  // Behavioral copy of the list contents and count
  logic signed [pal_pkg::DataW-1:0] list_mem [LIST_DEPTH];
  int unsigned                      list_cnt;

  pal_pkg::pal_rsp_t rsp_expect_q[$];
  int unsigned       err_cnt;
  bit                tx_idle_en;
  bit                rx_idle_en;
  bit                hold_req;
  bit                fill_bias;

  positional_array_list #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one request to the list copy and return the response it gives
  function automatic pal_pkg::pal_rsp_t predict_list_op(pal_pkg::pal_req_t req);
    pal_pkg::pal_rsp_t rsp;
    int unsigned       p;
    int unsigned       i;
    rsp.data   = '0;
    rsp.status = pal_pkg::ST_OK;
    p          = req.position;
    case (pal_pkg::pal_op_e'(req.opcode))
      pal_pkg::OP_INSERT: begin
        if (list_cnt >= LIST_DEPTH) begin
          rsp.status = pal_pkg::ST_FULL;
        end else if (p > list_cnt) begin
          rsp.status = pal_pkg::ST_RANGE;
        end else begin
          for (i = list_cnt; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = req.value;
          list_cnt++;
        end
      end
      pal_pkg::OP_DELETE, pal_pkg::OP_READ: begin
        if (list_cnt == 0) begin
          rsp.status = pal_pkg::ST_EMPTY;
        end else if (p >= list_cnt) begin
          rsp.status = pal_pkg::ST_RANGE;
        end else begin
          rsp.data = list_mem[p];
          if (pal_pkg::pal_op_e'(req.opcode) == pal_pkg::OP_DELETE) begin
            for (i = p; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
            list_cnt--;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.count = list_cnt[pal_pkg::CntW-1:0];
    return rsp;
  endfunction

  // Offer one request beat, hold it until taken, then maybe idle a burst
  task automatic send_req(input pal_pkg::pal_op_e op,
                          input logic [pal_pkg::PosW-1:0] pos,
                          input logic signed [pal_pkg::DataW-1:0] val);
    pal_pkg::pal_req_t req;
    req.opcode   = op;
    req.position = pos;
    req.value    = val;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    rsp_expect_q.push_back(predict_list_op(req));
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every expected response has come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (rsp_expect_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Delete and read on an empty list report empty even when out of range
  task automatic test_empty_list();
    send_req(pal_pkg::OP_READ, 5'd0, 32'sd0);
    send_req(pal_pkg::OP_DELETE, 5'd31, 32'sd0);
  endtask

  // Insert past the end, append, insert at the front and in the middle
  task automatic test_insert_positions();
    send_req(pal_pkg::OP_INSERT, 5'd1, 32'sd5);
    send_req(pal_pkg::OP_INSERT, 5'd0, 32'sh8000_0000);
    send_req(pal_pkg::OP_INSERT, 5'd1, 32'sh7fff_ffff);
    send_req(pal_pkg::OP_INSERT, 5'd0, -32'sd1);
    send_req(pal_pkg::OP_INSERT, 5'd2, 32'sd0);
    send_req(pal_pkg::OP_READ, 5'd0, 32'sd0);
    send_req(pal_pkg::OP_READ, 5'd4, 32'sd0);
    send_req(pal_pkg::OP_DELETE, 5'd1, 32'sd0);
  endtask

  // Fill the list, then hit the full and end-of-list cases and the no-op
  task automatic test_full_list();
    while (list_cnt < LIST_DEPTH) begin
      send_req(pal_pkg::OP_INSERT, 5'($urandom_range(0, list_cnt)), $urandom);
    end
    send_req(pal_pkg::OP_INSERT, 5'd31, 32'sd7);
    send_req(pal_pkg::OP_READ, 5'd15, 32'sd0);
    send_req(pal_pkg::OP_READ, 5'd16, 32'sd0);
    send_req(pal_pkg::OP_DELETE, 5'd15, 32'sd0);
    send_req(pal_pkg::OP_NOP, 5'd31, $urandom);
  endtask

  // Hold the response side for a long stretch while requests keep coming,
  // then pause the sender until the list has answered everything
  task automatic test_output_hold();
    hold_req = 1'b1;
    repeat (12) begin
      send_req(pal_pkg::OP_READ, 5'($urandom_range(0, 31)), $urandom);
    end
    wait_drain();
  endtask

  // Random requests: mostly valid positions for the current count, with the
  // fill direction flipping so the list swings between empty and full
  task automatic test_random_ops(input int unsigned n);
    int unsigned              k;
    int unsigned              w;
    pal_pkg::pal_op_e         op;
    logic [pal_pkg::PosW-1:0] pos;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) fill_bias = ~fill_bias;
      if ($urandom_range(0, 99) < 8) begin
        op  = pal_pkg::pal_op_e'($urandom_range(0, 3));
        pos = 5'($urandom_range(0, 31));
      end else begin
        w = $urandom_range(0, 99);
        if (w < (fill_bias ? 70 : 30)) begin
          op  = pal_pkg::OP_INSERT;
          pos = 5'($urandom_range(0, list_cnt));
        end else begin
          op  = (w % 3 == 0) ? pal_pkg::OP_READ : pal_pkg::OP_DELETE;
          pos = (list_cnt == 0) ? 5'd0 : 5'($urandom_range(0, list_cnt - 1));
        end
      end
      send_req(op, pos, $urandom);
    end
  endtask

  // Response side: random stall bursts, or one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare every response beat with the oldest expected one
  always @(posedge clk_i) begin
    pal_pkg::pal_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_expect_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected response at %0t: %p", $time, out_rsp_o);
      end else begin
        exp_rsp = rsp_expect_q.pop_front();
        if (out_rsp_o.data !== exp_rsp.data || out_rsp_o.status !== exp_rsp.status ||
            out_rsp_o.count !== exp_rsp.count) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch at %0t: data %0d/%0d status %0d/%0d count %0d/%0d (exp/got)",
                     $time, exp_rsp.data, out_rsp_o.data, exp_rsp.status,
                     out_rsp_o.status, exp_rsp.count, out_rsp_o.count);
          end
        end
      end
    end
  end

  // Bound the run
  initial begin
    #2400000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    list_cnt   = 0;
    err_cnt    = 0;
    hold_req   = 1'b0;
    fill_bias  = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_insert_positions();
    test_full_list();
    test_output_hold();
    test_random_ops(850);

    // Finish with back-to-back traffic on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_ops(150);

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && rsp_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
